// ----- rtl/core/rrht_pkg.sv -----
// Shared types and constants for the rounded rectangle hit test.
package rrht_pkg;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 3;

  // Byte-aligned width of the result tdata (inside_res in bit 0).
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_LEFT,
    CFG_RECT_TOP,
    CFG_RECT_WIDTH,
    CFG_RECT_HEIGHT,
    CFG_RADIUS_H,
    CFG_RADIUS_V
  } cfg_reg_e;

endpackage

// ----- rtl/core/rounded_rect_hit_test.sv -----
// Rounded rectangle hit test: streaming point-in-shape pipeline with a config port.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid_i/tready_o       point_x, point_y
//   m_axis    out        m_axis_tvalid_o/tready_i       inside_res
//   cfg       in         cfg_we_i (no back-pressure)    cfg_index_i, cfg_data_i
//
// One point is accepted per clock while s_axis_tready_o is high; its result is registered at the end of the datapath.
// The rate is set by the six-stage datapath, which advances as a whole whenever the pipeline is not held.
// Reset clears the valid bits, the configuration registers and their derived radii.
// When the result is not taken and another one arrives, the waiting result moves to a skid register and the
// pipeline, together with s_axis_tready_o, holds until the skid register drains.
module rounded_rect_hit_test #(
  parameter int unsigned COORD_WIDTH = 16,
  localparam int unsigned InTdataW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0: point_x, point_y, zero fill.
  input  logic [InTdataW-1:0]               s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Fields from bit 0: inside_res, zero fill.
  output logic [rrht_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [rrht_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [COORD_WIDTH-1:0]            cfg_data_i
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned L   = COORD_WIDTH - 1;  // unsigned size and radius width
  localparam int unsigned P_W = 2 * L;            // one cross product
  localparam int unsigned S_W = 4 * L;            // one squared cross product

  // Configuration registers.
  logic signed [CW-1:0] left_q, top_q, rad_h_q, rad_v_q;
  logic [L-1:0]         width_q, height_q;

  // Radii made absolute, doubled and clamped to the size, plus far corner centers.
  logic [L-1:0]  rx_q, ry_q, rx_d, ry_d;
  logic [CW-1:0] wrx_q, hry_q, wrx_d, hry_d;
  logic [CW-1:0] rad_h_abs, rad_v_abs;
  logic [CW:0]   rad_h_dbl, rad_v_dbl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      rad_h_q  <= '0;
      rad_v_q  <= '0;
    end else if (cfg_we_i) begin
      case (rrht_pkg::cfg_reg_e'(cfg_index_i))
        rrht_pkg::CFG_RECT_LEFT:   left_q   <= cfg_data_i;
        rrht_pkg::CFG_RECT_TOP:    top_q    <= cfg_data_i;
        rrht_pkg::CFG_RECT_WIDTH:  width_q  <= cfg_data_i[L-1:0];
        rrht_pkg::CFG_RECT_HEIGHT: height_q <= cfg_data_i[L-1:0];
        rrht_pkg::CFG_RADIUS_H:    rad_h_q  <= cfg_data_i;
        rrht_pkg::CFG_RADIUS_V:    rad_v_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rad_h_abs = rad_h_q[CW-1] ? (~rad_h_q + 1'b1) : rad_h_q;
    rad_v_abs = rad_v_q[CW-1] ? (~rad_v_q + 1'b1) : rad_v_q;
    rad_h_dbl = {rad_h_abs, 1'b0};
    rad_v_dbl = {rad_v_abs, 1'b0};
    // Doubled units: clamping to the size here is clamping to half the size.
    rx_d  = (rad_h_dbl < (CW + 1)'(width_q))  ? rad_h_dbl[L-1:0] : width_q;
    ry_d  = (rad_v_dbl < (CW + 1)'(height_q)) ? rad_v_dbl[L-1:0] : height_q;
    wrx_d = {width_q, 1'b0}  - CW'(rx_d);
    hry_d = {height_q, 1'b0} - CW'(ry_d);
  end

  // The derived values settle in the cycle after a write, before any item needs them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q  <= '0;
      ry_q  <= '0;
      wrx_q <= '0;
      hry_q <= '0;
    end else begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      wrx_q <= wrx_d;
      hry_q <= hry_d;
    end
  end

  // Pipeline control.
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic out_valid_q, out_res_q, skid_valid_q, skid_res_q;
  logic out_load;

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;
  assign out_load        = en && (!out_valid_q || m_axis_tready_i || v5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      v5_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q <= s_axis_tvalid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        if (out_load) begin
          out_valid_q <= v5_q;
        end
        // A waiting result that would be overwritten moves to the skid register.
        if (out_valid_q && !m_axis_tready_i && v5_q) begin
          skid_valid_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1: point relative to the rectangle origin.
  logic signed [CW:0] x_q, y_q;

  // Stage 2: box and band decisions, distances to the corner centers.
  logic          inbox, band_x, band_y, x_lo, y_lo;
  logic [CW-1:0] xd, yd, dx_full, dy_full;
  logic          dec2_q, hit2_q;
  logic [L-1:0]  dx_q, dy_q;

  always_comb begin
    inbox   = !x_q[CW] && !y_q[CW] && (x_q[CW-1:0] < CW'(width_q))
              && (y_q[CW-1:0] < CW'(height_q));
    xd      = {x_q[L-1:0], 1'b0};
    yd      = {y_q[L-1:0], 1'b0};
    x_lo    = xd < CW'(rx_q);
    y_lo    = yd < CW'(ry_q);
    band_x  = !x_lo && (xd <= wrx_q);
    band_y  = !y_lo && (yd <= hry_q);
    dx_full = x_lo ? (CW'(rx_q) - xd) : (xd - wrx_q);
    dy_full = y_lo ? (CW'(ry_q) - yd) : (yd - hry_q);
  end

  // Stage 3: cross products dx*ry, dy*rx and rx*ry.
  logic         dec3_q, hit3_q;
  logic [P_W-1:0] prod_q [3];

  // Stage 4: each product squared as high/low partial products.
  logic         dec4_q, hit4_q;
  logic [P_W-1:0] pp_hh_q [3];
  logic [P_W-1:0] pp_hl_q [3];
  logic [P_W-1:0] pp_ll_q [3];
  logic [L-1:0]   p_hi [3];
  logic [L-1:0]   p_lo [3];

  // Stage 5: assembled squares.
  logic         dec5_q, hit5_q;
  logic [S_W-1:0] sq_d [3];
  logic [S_W-1:0] sq_q [3];

  // Stage 6: ellipse comparison.
  logic [S_W:0] sum_ab;
  logic         in_ellipse, res_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_hi[i] = prod_q[i][P_W-1:L];
      p_lo[i] = prod_q[i][L-1:0];
      sq_d[i] = (S_W'(pp_hh_q[i]) << (2 * L)) + (S_W'(pp_hl_q[i]) << (L + 1))
                + S_W'(pp_ll_q[i]);
    end
    sum_ab     = (S_W + 1)'(sq_q[0]) + (S_W + 1)'(sq_q[1]);
    in_ellipse = sum_ab <= (S_W + 1)'(sq_q[2]);
    res_d      = dec5_q ? hit5_q : in_ellipse;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= (CW + 1)'($signed(s_axis_tdata_i[CW-1:0])) - (CW + 1)'(left_q);
      y_q <= (CW + 1)'($signed(s_axis_tdata_i[2*CW-1:CW])) - (CW + 1)'(top_q);

      dec2_q <= !inbox || band_x || band_y || (rx_q == '0) || (ry_q == '0);
      hit2_q <= inbox;
      dx_q   <= dx_full[L-1:0];
      dy_q   <= dy_full[L-1:0];

      dec3_q    <= dec2_q;
      hit3_q    <= hit2_q;
      prod_q[0] <= P_W'(dx_q) * P_W'(ry_q);
      prod_q[1] <= P_W'(dy_q) * P_W'(rx_q);
      prod_q[2] <= P_W'(rx_q) * P_W'(ry_q);

      dec4_q <= dec3_q;
      hit4_q <= hit3_q;
      for (int i = 0; i < 3; i++) begin
        pp_hh_q[i] <= P_W'(p_hi[i]) * P_W'(p_hi[i]);
        pp_hl_q[i] <= P_W'(p_hi[i]) * P_W'(p_lo[i]);
        pp_ll_q[i] <= P_W'(p_lo[i]) * P_W'(p_lo[i]);
      end

      dec5_q <= dec4_q;
      hit5_q <= hit4_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= sq_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && out_valid_q && !m_axis_tready_i && v5_q) begin
      skid_res_q <= out_res_q;
    end
    if (out_load) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = skid_valid_q || out_valid_q;
  assign m_axis_tdata_o  = {(rrht_pkg::OUT_TDATA_W - 1)'(0),
                            skid_valid_q ? skid_res_q : out_res_q};

endmodule
